// ===== src/lsfo_pkg.sv =====
// Shared types, constants and pixel arithmetic for the strobe and flash overlay.
`default_nettype none

package lsfo_pkg;

  // Default values of the top-level parameters.
  localparam int NUM_STRIPS_DEF      = 7;
  localparam int LEVEL_FRAC_BITS_DEF = 8;

  // 255 * dt needs 40 bits for any 32-bit time step.
  localparam int PROD_W = 40;
  // Widest divisor is a 14-bit time constant.
  localparam int DEN_W = 14;
  // Strip compare width: holds any strip count up to 16.
  localparam int STRIP_CMP_W = 5;
  localparam int CFG_DATA_W = 16;

  // Item kinds.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_STROBE_PERIOD = 3'd0;
  localparam logic [2:0] REG_ATTACK        = 3'd1;
  localparam logic [2:0] REG_RELEASE       = 3'd2;
  localparam logic [2:0] REG_WHITEN        = 3'd3;
  localparam logic [2:0] REG_FIRST_STEP    = 3'd4;
  localparam logic [2:0] REG_STROBE_LAST   = 3'd5;

  // Register reset values.
  localparam logic [9:0]  STROBE_PERIOD_RST = 10'd66;
  localparam logic [13:0] ATTACK_RST        = 14'd200;
  localparam logic [13:0] RELEASE_RST       = 14'd400;
  localparam logic [7:0]  WHITEN_RST        = 8'd170;
  localparam logic [9:0]  FIRST_STEP_RST    = 10'd16;
  localparam logic [2:0]  STROBE_LAST_RST   = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] time_ms;
    logic        strobe_button;
    logic        flash_button;
    logic [7:0]  sample_red;
    logic [7:0]  sample_green;
    logic [7:0]  sample_blue;
    logic [2:0]  strip_index;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
  } in_word_t;

  typedef struct packed {
    logic [2:0] strip_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] flash_level_out;
  } out_word_t;

  typedef struct packed {
    logic [2:0]            index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  // Register values as the datapath sees them (zero time constants read as one).
  typedef struct packed {
    logic [9:0]  strobe_period_ms;
    logic [13:0] attack_ms;
    logic [13:0] release_ms;
    logic [7:0]  whiten_amount;
    logic [9:0]  first_step_ms;
    logic [2:0]  strobe_last_strip;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PHASE,
    ST_LEVEL,
    ST_ROUND
  } lsfo_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_frame;
    logic load_pixel;
    logic div_start_phase;
    logic div_start_level;
    logic take_phase;
    logic take_level;
  } lsfo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic div_done;
  } lsfo_stat_t;

  // Scale an 8-bit value by (s + 1) / 256.
  function automatic logic [7:0] sc8(input logic [7:0] x, input logic [7:0] s);
    logic [16:0] p;
    p = 17'(x) * (17'(s) + 17'd1);
    return p[15:8];
  endfunction

  // 8-bit add that saturates at full scale.
  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // Push one colour channel toward white.
  function automatic logic [7:0] whiten(input logic [7:0] c, input logic [7:0] w);
    return sat_add8(c, sc8(8'hFF - c, w));
  endfunction

endpackage

`default_nettype wire

// ===== src/lsfo_chan_if.sv =====
// Valid/ready channel carrying one payload word.
`default_nettype none

interface lsfo_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lsfo_regs.sv =====
// Configuration register file.
`default_nettype none

module lsfo_regs import lsfo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      we,
  input  cfg_word_t wr_word,
  output cfg_regs_t regs
);

  logic [9:0]  strobe_period_r;
  logic [13:0] attack_r;
  logic [13:0] release_r;
  logic [7:0]  whiten_r;
  logic [9:0]  first_step_r;
  logic [2:0]  strobe_last_r;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_period_r <= STROBE_PERIOD_RST;
      attack_r        <= ATTACK_RST;
      release_r       <= RELEASE_RST;
      whiten_r        <= WHITEN_RST;
      first_step_r    <= FIRST_STEP_RST;
      strobe_last_r   <= STROBE_LAST_RST;
    end else if (we) begin
      case (wr_word.index)
        REG_STROBE_PERIOD: strobe_period_r <= wr_word.value[9:0];
        REG_ATTACK:        attack_r        <= wr_word.value[13:0];
        REG_RELEASE:       release_r       <= wr_word.value[13:0];
        REG_WHITEN:        whiten_r        <= wr_word.value[7:0];
        REG_FIRST_STEP:    first_step_r    <= wr_word.value[9:0];
        REG_STROBE_LAST:   strobe_last_r   <= wr_word.value[2:0];
        default: begin
        end
      endcase
    end
  end

  // A zero period or time constant acts as one.
  always_comb begin
    regs.strobe_period_ms  = (strobe_period_r == '0) ? 10'd1 : strobe_period_r;
    regs.attack_ms         = (attack_r == '0) ? 14'd1 : attack_r;
    regs.release_ms        = (release_r == '0) ? 14'd1 : release_r;
    regs.whiten_amount     = whiten_r;
    regs.first_step_ms     = first_step_r;
    regs.strobe_last_strip = strobe_last_r;
  end

endmodule

`default_nettype wire

// ===== src/lsfo_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lsfo_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             busy,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic             fits;
  logic [DEN_W:0]   rem_sub;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== src/lsfo_ctrl.sv =====
// Controller: item acceptance, frame sequencing and output register handshake.
`default_nettype none

module lsfo_ctrl import lsfo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lsfo_stat_t stat,
  output lsfo_cmd_t  cmd
);

  lsfo_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_fire;

  // A pixel needs a free output register; a frame does not.
  assign in_ready = (state_r == ST_IDLE) &&
                    ((in_opcode == OP_FRAME) || !out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_opcode == OP_FRAME) state_nxt = ST_PHASE;
      end
      ST_PHASE: begin
        if (stat.div_done) state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (stat.div_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_frame      = in_fire && in_opcode == OP_FRAME;
        cmd.div_start_phase = in_fire && in_opcode == OP_FRAME;
        cmd.load_pixel      = in_fire && in_opcode == OP_PIXEL;
      end
      ST_PHASE: begin
        cmd.take_phase      = stat.div_done;
        cmd.div_start_level = stat.div_done;
      end
      ST_LEVEL: begin
        cmd.take_level = stat.div_done;
      end
      default: begin
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_pixel) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/lsfo_dp.sv =====
// Datapath: frame state, flash envelope, strobe phase and the pixel overlay.
`default_nettype none

module lsfo_dp import lsfo_pkg::*; #(
  parameter int NUM_STRIPS      = NUM_STRIPS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lsfo_cmd_t  cmd,
  output lsfo_stat_t stat,
  input  in_word_t   in_word,
  input  cfg_regs_t  regs,
  output out_word_t  out_word
);

  localparam int LW = 8 + LEVEL_FRAC_BITS;
  localparam int NW = PROD_W + LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] LEVEL_FULL = {8'hFF, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [LW-1:0] LEVEL_HALF = LW'(1) << (LEVEL_FRAC_BITS - 1);
  localparam logic [STRIP_CMP_W-1:0] STRIP_LIMIT = STRIP_CMP_W'(NUM_STRIPS);

  // Frame state.
  logic [LW-1:0]     level_r, level_nxt;
  logic [7:0]        lvl_r, lvl_nxt;
  logic [31:0]       last_time_r;
  logic              have_last_r;
  logic              colour_pending_r;
  logic [23:0]       flash_colour_r;
  logic              strobe_active_r;
  logic              strobe_on_phase_r;
  logic [PROD_W-1:0] prod_r;
  logic              btn_r;
  out_word_t         out_r, out_nxt;

  logic [31:0]       dt;
  logic [PROD_W-1:0] prod_nxt;
  logic [23:0]       colour_nxt;

  logic [NW-1:0]     div_num;
  logic [DEN_W-1:0]  div_den;
  logic [NW-1:0]     div_quo;
  logic              div_start;
  logic [LW-1:0]     room;
  logic [LW:0]       round_sum;

  // Shared divider: time / period first, then the envelope step.
  assign div_start = cmd.div_start_phase || cmd.div_start_level;
  assign div_num   = cmd.div_start_level ? {prod_r, {LEVEL_FRAC_BITS{1'b0}}}
                                         : NW'(in_word.time_ms);
  assign div_den   = cmd.div_start_level ? (btn_r ? regs.attack_ms : regs.release_ms)
                                         : DEN_W'(regs.strobe_period_ms);

  lsfo_div #(
    .NUM_W(NW),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .busy (stat.div_busy),
    .done (stat.div_done)
  );

  // Time step and the 255 * dt numerator.
  always_comb begin
    dt         = have_last_r ? (in_word.time_ms - last_time_r)
                             : 32'(regs.first_step_ms);
    prod_nxt   = {dt, 8'h00} - {8'h00, dt};
    colour_nxt = {whiten(in_word.sample_red,   regs.whiten_amount),
                  whiten(in_word.sample_green, regs.whiten_amount),
                  whiten(in_word.sample_blue,  regs.whiten_amount)};
  end

  // Envelope step: attack while held, release otherwise.
  always_comb begin
    room      = LEVEL_FULL - level_r;
    level_nxt = level_r;
    if (btn_r) begin
      if (level_r < LEVEL_FULL) begin
        level_nxt = (div_quo >= NW'(room)) ? LEVEL_FULL : level_r + LW'(div_quo);
      end
    end else if (level_r != '0) begin
      level_nxt = (div_quo >= NW'(level_r)) ? '0 : level_r - LW'(div_quo);
    end
  end

  // Rounded 8-bit level, refreshed every cycle from the envelope.
  always_comb begin
    round_sum = {1'b0, level_r} + {1'b0, LEVEL_HALF};
    lvl_nxt   = (round_sum[LW:LEVEL_FRAC_BITS] > 9'd255) ? 8'hFF
                                                         : round_sum[LEVEL_FRAC_BITS+7:LEVEL_FRAC_BITS];
  end

  // Frame registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r           <= '0;
      lvl_r             <= '0;
      last_time_r       <= '0;
      have_last_r       <= 1'b0;
      colour_pending_r  <= 1'b1;
      flash_colour_r    <= 24'hFFFFFF;
      strobe_active_r   <= 1'b0;
      strobe_on_phase_r <= 1'b0;
    end else begin
      lvl_r <= lvl_nxt;
      if (cmd.load_frame) begin
        last_time_r      <= in_word.time_ms;
        have_last_r      <= 1'b1;
        strobe_active_r  <= in_word.strobe_button;
        colour_pending_r <= !in_word.flash_button;
        if (in_word.flash_button && colour_pending_r) flash_colour_r <= colour_nxt;
      end
      if (cmd.take_phase) strobe_on_phase_r <= !div_quo[0];
      if (cmd.take_level) level_r <= level_nxt;
    end
  end

  // Frame operands held for the envelope division.
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      prod_r <= prod_nxt;
      btn_r  <= in_word.flash_button;
    end
  end

  // Pixel overlay: strobe override, then additive flash.
  always_comb begin
    logic       in_range;
    logic       strobe_hit;
    logic [7:0] strobe_v;
    logic [7:0] lvl_sel;
    logic [7:0] base_r, base_g, base_b;
    in_range   = {2'b00, in_word.strip_index} < STRIP_LIMIT;
    strobe_hit = in_range && strobe_active_r &&
                 (in_word.strip_index <= regs.strobe_last_strip);
    strobe_v   = strobe_on_phase_r ? 8'hFF : 8'h00;
    lvl_sel    = in_range ? lvl_r : 8'h00;
    base_r     = strobe_hit ? strobe_v : in_word.pixel_red;
    base_g     = strobe_hit ? strobe_v : in_word.pixel_green;
    base_b     = strobe_hit ? strobe_v : in_word.pixel_blue;
    out_nxt.strip_out       = in_word.strip_index;
    out_nxt.red_out         = sat_add8(base_r, sc8(flash_colour_r[23:16], lvl_sel));
    out_nxt.green_out       = sat_add8(base_g, sc8(flash_colour_r[15:8], lvl_sel));
    out_nxt.blue_out        = sat_add8(base_b, sc8(flash_colour_r[7:0], lvl_sel));
    out_nxt.flash_level_out = lvl_sel;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_pixel) out_r <= out_nxt;
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

// ===== src/led_strobe_flash_overlay.sv =====
// Top level of the LED strobe and flash overlay.
//
//   Channel  Direction  Word                         Accepted when
//   in_ch    sink       frame or pixel (in_word_t)   valid && ready
//   out_ch   source     processed pixel (out_word_t) valid && ready
//   cfg_ch   sink       register write (cfg_word_t)  valid && ready (ready tied high)
//
// A pixel word's result sits in the output register the next cycle, and a new pixel is
// taken each cycle while no frame is busy and that register is empty or being drained.
// A frame word occupies the block while the shared bit-serial divider runs time / period
// and then the envelope step. Reset is synchronous and active low.
// A stalled output holds its word; further pixels wait until the register frees up.
`default_nettype none

module led_strobe_flash_overlay import lsfo_pkg::*; #(
  parameter int NUM_STRIPS      = NUM_STRIPS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lsfo_chan_if.sink   in_ch,
  lsfo_chan_if.source out_ch,
  lsfo_chan_if.sink   cfg_ch
);

  lsfo_cmd_t  cmd;
  lsfo_stat_t stat;
  cfg_regs_t  regs;
  in_word_t   in_word;
  out_word_t  out_word;
  cfg_word_t  cfg_word;
  logic       in_fire;

  assign in_word      = in_ch.data;
  assign cfg_word     = cfg_ch.data;
  assign out_ch.data  = out_word;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  lsfo_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (cfg_ch.valid),
    .wr_word(cfg_word),
    .regs   (regs)
  );

  lsfo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_opcode(in_word.opcode),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsfo_dp #(
    .NUM_STRIPS     (NUM_STRIPS),
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_word (in_word),
    .regs    (regs),
    .out_word(out_word)
  );

  // A pixel is never taken over a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.opcode == OP_PIXEL |-> !out_ch.valid || out_ch.ready)
    else $error("pixel accepted over a pending result");

  // A frame keeps the block busy on the following cycle.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.opcode == OP_FRAME |=> !in_fire)
    else $error("word accepted right after a frame");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start_phase || cmd.div_start_level) |-> !stat.div_busy)
    else $error("divider started while busy");

  // A result appears only after a pixel was accepted.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_fire && in_word.opcode == OP_PIXEL))
    else $error("result without a pixel");

endmodule

`default_nettype wire
